// ===== hw/rtl/lenient_utf8_decoder_assert.svh =====
// Assertion macros for the lenient UTF-8 decoder.
// Included by RTL modules that carry concurrent checks; depends on nothing.
`ifndef LENIENT_UTF8_DECODER_ASSERT_SVH
`define LENIENT_UTF8_DECODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define LUTF8_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lutf8 check failed");
`define LUTF8_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("lutf8 check failed");
`else
`define LUTF8_ASSERT(lbl, clk, rst, prop)
`define LUTF8_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/lutf8_pkg.sv =====
// Shared types, constants and the lead-byte classifier of the UTF-8 decoder.
// Used by the front end, the command queue, the back end and the top level.
`default_nettype none
package lutf8_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CP_W            = 21;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            passed_raw;
    logic            end_of_text;
  } res_t;

  typedef struct packed {
    logic [1:0]      flush_cnt;
    logic [2:0][7:0] held;
    logic            tail_valid;
    res_t            tail;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_1   = 3'd1;
  localparam logic [2:0] LEN_2   = 3'd2;
  localparam logic [2:0] LEN_3   = 3'd3;
  localparam logic [2:0] LEN_4   = 3'd4;

  function automatic logic [2:0] seq_length(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) len = LEN_1;
    else if ((b & 8'he0) == 8'hc0) len = LEN_2;
    else if ((b & 8'hf0) == 8'he0) len = LEN_3;
    else if ((b & 8'hf8) == 8'hf0) len = LEN_4;
    else len = LEN_BAD;
    return len;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lenient_utf8_decoder.sv =====
// Top level of the lenient UTF-8 decoder: front end, command queue, back end.
// Depends on lutf8_pkg, lutf8_front, lutf8_queue and lutf8_back.
//
//   channel  | direction | payload         | handshake
//   byte     | in        | lutf8_pkg::in_t  | byte_valid / byte_stall
//   code     | out       | lutf8_pkg::res_t | code_valid / code_stall
//
// One byte is taken per cycle while byte_stall is low. A byte that completes a sequence or is plain
// ASCII leaves one result; a broken or flushed sequence leaves up to four,
// played out by the back end at one result per cycle from the command queue while code_stall is low.
// byte_stall is high while the QUEUE_DEPTH-entry queue is full.
// Reset is synchronous and clears the held count, the queue and the output.
// code_stall holds the output register; the front end keeps accepting until the queue is full.
`default_nettype none
module lenient_utf8_decoder #(
  parameter int QUEUE_DEPTH = lutf8_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              byte_valid,
  output logic                   byte_stall,
  input  wire lutf8_pkg::in_t    byte_beat,
  output logic                   code_valid,
  input  wire logic              code_stall,
  output lutf8_pkg::res_t        code_beat
);

  logic               accept;
  logic               push;
  logic               pop;
  lutf8_pkg::cmd_t    cmd;
  lutf8_pkg::cmd_t    head;
  lutf8_pkg::q_stat_t stat;

  assign byte_stall = stat.full;
  assign accept     = byte_valid && !byte_stall;

  lutf8_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .beat   (byte_beat),
    .push   (push),
    .cmd    (cmd)
  );

  lutf8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  lutf8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .stat       (stat),
    .pop        (pop),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_beat  (code_beat)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/lutf8_front.sv =====
// Front end: holds the unfinished sequence and turns bytes into commands.
// Depends on lutf8_pkg.
`default_nettype none
module lutf8_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire lutf8_pkg::in_t    beat,
  output logic                   push,
  output lutf8_pkg::cmd_t        cmd
);

  logic [2:0][7:0] pend;
  logic [1:0]      count;
  logic [1:0]      count_next;
  logic            wr_en;
  logic [1:0]      wr_idx;
  logic [2:0]      lead_len;
  logic [2:0]      byte_len;
  logic            is_cont;
  logic [7:0]      b;
  logic            fin;
  logic            emit;

  always_comb begin
    b        = beat.data_byte;
    fin      = beat.final_byte;
    lead_len = lutf8_pkg::seq_length(pend[0]);
    byte_len = lutf8_pkg::seq_length(b);
    is_cont  = (b[7:6] == 2'b10);

    cmd                  = '0;
    cmd.held             = pend;
    cmd.tail.end_of_text = fin;
    count_next           = count;
    wr_en                = 1'b0;
    wr_idx               = count;
    emit                 = 1'b0;

    if (count != 2'd0 && is_cont) begin
      if (({1'b0, count} + 3'd1) == lead_len) begin
        cmd.tail_valid      = 1'b1;
        cmd.tail.passed_raw = 1'b0;
        unique case (lead_len)
          lutf8_pkg::LEN_2:
            cmd.tail.code_point = {10'd0, pend[0][4:0], b[5:0]};
          lutf8_pkg::LEN_3:
            cmd.tail.code_point = {5'd0, pend[0][3:0], pend[1][5:0], b[5:0]};
          default:
            cmd.tail.code_point = {pend[0][2:0], pend[1][5:0], pend[2][5:0], b[5:0]};
        endcase
        emit       = 1'b1;
        count_next = 2'd0;
      end else if (fin) begin
        cmd.flush_cnt       = count;
        cmd.tail_valid      = 1'b1;
        cmd.tail.passed_raw = 1'b1;
        cmd.tail.code_point = {13'd0, b};
        emit                = 1'b1;
        count_next          = 2'd0;
      end else begin
        wr_en      = 1'b1;
        count_next = count + 2'd1;
      end
    end else begin
      cmd.flush_cnt       = count;
      cmd.tail.code_point = {13'd0, b};
      count_next          = 2'd0;
      unique case (byte_len)
        lutf8_pkg::LEN_1: begin
          cmd.tail_valid      = 1'b1;
          cmd.tail.passed_raw = 1'b0;
        end
        lutf8_pkg::LEN_BAD: begin
          cmd.tail_valid      = 1'b1;
          cmd.tail.passed_raw = 1'b1;
        end
        default: begin
          if (fin) begin
            cmd.tail_valid      = 1'b1;
            cmd.tail.passed_raw = 1'b1;
          end else begin
            wr_en      = 1'b1;
            wr_idx     = 2'd0;
            count_next = 2'd1;
          end
        end
      endcase
      emit = cmd.tail_valid || (count != 2'd0);
    end

    push = accept && emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      pend[wr_idx] <= b;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lutf8_queue.sv =====
// Command queue between the front end and the back end.
// Depends on lutf8_pkg.
`default_nettype none
module lutf8_queue #(
  parameter int DEPTH = lutf8_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire lutf8_pkg::cmd_t   push_cmd,
  input  wire logic              pop,
  output lutf8_pkg::cmd_t        head,
  output lutf8_pkg::q_stat_t     stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  lutf8_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lutf8_back.sv =====
// Back end: plays out each command as raw flush beats and, if valid, a tail beat.
// Depends on lutf8_pkg and the assertion macro header.
`default_nettype none
`include "lenient_utf8_decoder_assert.svh"
module lutf8_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lutf8_pkg::cmd_t   head,
  input  wire lutf8_pkg::q_stat_t stat,
  output logic                   pop,
  output logic                   code_valid,
  input  wire logic              code_stall,
  output lutf8_pkg::res_t        code_beat
);

  logic [1:0]      idx;
  logic [2:0]      total;
  logic            last;
  logic            load;
  logic            take;
  lutf8_pkg::res_t cur;

  always_comb begin
    total = {1'b0, head.flush_cnt} + {2'b00, head.tail_valid};
    last  = (({1'b0, idx} + 3'd1) == total);
    load  = !code_valid || !code_stall;
    take  = load && !stat.empty;
    pop   = take && last;
    if (idx < head.flush_cnt) begin
      cur.code_point  = {13'd0, head.held[idx]};
      cur.passed_raw  = 1'b1;
      cur.end_of_text = 1'b0;
    end else begin
      cur = head.tail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
      idx        <= 2'd0;
    end else begin
      if (load) begin
        code_valid <= !stat.empty;
      end
      if (take) begin
        idx <= last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      code_beat <= cur;
    end
  end

  `LUTF8_ASSERT(a_pop_not_empty, clk, rst, pop |-> !stat.empty)
  `LUTF8_ASSERT(a_end_is_last, clk, rst, (take && cur.end_of_text) |-> pop)
  `LUTF8_ASSERT(a_raw_is_byte, clk, rst,
                (code_valid && code_beat.passed_raw) |-> (code_beat.code_point[20:8] == 13'd0))
  `LUTF8_ASSERT(a_idx_in_range, clk, rst, !stat.empty |-> ({1'b0, idx} < total))

endmodule
`default_nettype wire
